FILE: hw/rtl/utf8_indic_script_transliterator_core_macros.svh
// Assertion macros shared by the transliterator RTL.
`ifndef UTF8_INDIC_SCRIPT_TRANSLITERATOR_CORE_MACROS_SVH
`define UTF8_INDIC_SCRIPT_TRANSLITERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define UIST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define UIST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/uist_pkg.sv
// Types, constants and helper functions of the UTF-8 Indic transliterator.
package uist_pkg;

  localparam int CP_W = 21;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Script codes held in the configuration registers
  localparam logic [1:0] SCRIPT_NONE = 2'd0;
  localparam logic [1:0] SCRIPT_DEVA = 2'd1;
  localparam logic [1:0] SCRIPT_BENG = 2'd2;
  localparam logic [1:0] SCRIPT_TELU = 2'd3;

  localparam logic [CP_W-1:0] DANDA      = 21'h000964;
  localparam logic [CP_W-1:0] DOUBLE_DANDA = 21'h000965;
  localparam logic [CP_W-1:0] SHIFT_SPAN = 21'h00006F;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       emit;
    logic [1:0] cp_idx;
    logic [1:0] byte_idx;
    logic       run_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] new_ncps;
    logic [1:0] ncps;
    logic [1:0] cur_len_m1;
    logic       slot_free;
  } dp_sts_t;

  function automatic logic [11:0] script_base(input logic [1:0] code);
    logic [11:0] b;
    unique case (code)
      SCRIPT_DEVA: b = 12'h900;
      SCRIPT_BENG: b = 12'h980;
      SCRIPT_TELU: b = 12'hC00;
      default:     b = 12'h000;
    endcase
    return b;
  endfunction

  // Sequence length from the lead byte; 0 marks an invalid lead
  function automatic logic [2:0] lead_class(input logic [7:0] c);
    logic [2:0] len;
    if (c[7] == 1'b0)            len = 3'd1;
    else if (c[7:5] == 3'b110)   len = 3'd2;
    else if (c[7:4] == 4'b1110)  len = 3'd3;
    else if (c[7:3] == 5'b11110) len = 3'd4;
    else                         len = 3'd0;
    return len;
  endfunction

  // Move a code point from the source block to the target block
  function automatic logic [CP_W-1:0] shift_cp(input logic [CP_W-1:0] cp,
                                               input logic [1:0] src,
                                               input logic [1:0] tgt);
    logic [CP_W-1:0] sb;
    logic [CP_W-1:0] tb;
    logic [CP_W-1:0] diff;
    logic [CP_W-1:0] res;
    sb   = CP_W'(script_base(src));
    tb   = CP_W'(script_base(tgt));
    diff = cp - sb;
    res  = cp;
    if (cp != DANDA && cp != DOUBLE_DANDA && cp >= sb && diff <= SHIFT_SPAN) begin
      res = tb + diff;
    end
    return res;
  endfunction

  // UTF-8 length minus one of a code point
  function automatic logic [1:0] enc_len_m1(input logic [CP_W-1:0] cp);
    logic [1:0] l;
    if (cp <= 21'h00007F)      l = 2'd0;
    else if (cp <= 21'h0007FF) l = 2'd1;
    else if (cp <= 21'h00FFFF) l = 2'd2;
    else                       l = 2'd3;
    return l;
  endfunction

  // One byte of the UTF-8 encoding
  function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] cp,
                                          input logic [1:0] len_m1,
                                          input logic [1:0] k);
    logic [7:0] b;
    case (len_m1)
      2'd0: b = cp[7:0];
      2'd1: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        case (k)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/uist_dp.sv
// Datapath: sequence gathering, decode, script shift and UTF-8 encode.
module uist_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          src_script,
  input  logic [1:0]          tgt_script,
  input  uist_pkg::in_item_t  in_data,
  input  uist_pkg::dp_cmd_t   cmd,
  output uist_pkg::dp_sts_t   sts,
  input  logic                out_ready,
  output logic                out_valid,
  output uist_pkg::out_item_t out_data
);
  import uist_pkg::*;

  // Gathered bytes of an unfinished sequence
  logic [7:0]      pend_r [3];
  logic [1:0]      pcnt_r, pcnt_nxt;
  logic [2:0]      need_r, need_nxt;

  // Code points of the transaction being emitted
  logic [CP_W-1:0] cp_r [3];
  logic [1:0]      len_r [3];
  logic [1:0]      ncps_r;
  logic            eot_r;

  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r;

  logic [CP_W-1:0] cp_raw [3];
  logic [CP_W-1:0] cp_sh [3];
  logic [1:0]      len_new [3];
  logic [1:0]      n_new;
  logic            raw_item;
  logic            pend_we;
  logic [2:0]      cls;
  logic            passthru;
  logic [7:0]      c;
  logic [CP_W-1:0] cur_cp;
  logic [1:0]      cur_len;

  assign c        = in_data.in_byte;
  assign cls      = lead_class(c);
  assign passthru = (src_script == SCRIPT_NONE) || (tgt_script == SCRIPT_NONE);

  // Work out the code points that the incoming byte releases
  always_comb begin
    cp_raw[0] = '0;
    cp_raw[1] = '0;
    cp_raw[2] = '0;
    n_new     = 2'd0;
    raw_item  = 1'b0;
    pend_we   = 1'b0;
    pcnt_nxt  = pcnt_r;
    need_nxt  = need_r;
    if (passthru) begin
      cp_raw[0] = CP_W'(c);
      n_new     = 2'd1;
      raw_item  = 1'b1;
      pcnt_nxt  = 2'd0;
      need_nxt  = 3'd0;
    end else if (pcnt_r == 2'd0) begin
      if (cls <= 3'd1) begin
        cp_raw[0] = CP_W'(c);
        n_new     = 2'd1;
      end else if (in_data.end_of_text) begin
        // lone lead byte at end of text
        cp_raw[0] = CP_W'(c);
        n_new     = 2'd1;
      end else begin
        pend_we  = 1'b1;
        pcnt_nxt = 2'd1;
        need_nxt = cls;
      end
    end else if ((3'(pcnt_r) + 3'd1) >= need_r) begin
      // sequence complete: decode it
      case (need_r)
        3'd2:    cp_raw[0] = CP_W'({pend_r[0][4:0], c[5:0]});
        3'd3:    cp_raw[0] = CP_W'({pend_r[0][3:0], pend_r[1][5:0], c[5:0]});
        default: cp_raw[0] = {pend_r[0][2:0], pend_r[1][5:0], pend_r[2][5:0], c[5:0]};
      endcase
      n_new    = 2'd1;
      pcnt_nxt = 2'd0;
      need_nxt = 3'd0;
    end else if (in_data.end_of_text) begin
      // unfinished at end of text: lead alone, then re-parse the rest
      cp_raw[0] = CP_W'(pend_r[0]);
      pcnt_nxt  = 2'd0;
      need_nxt  = 3'd0;
      if (pcnt_r == 2'd1) begin
        cp_raw[1] = CP_W'(c);
        n_new     = 2'd2;
      end else if (lead_class(pend_r[1]) == 3'd2) begin
        cp_raw[1] = CP_W'({pend_r[1][4:0], c[5:0]});
        n_new     = 2'd2;
      end else begin
        cp_raw[1] = CP_W'(pend_r[1]);
        cp_raw[2] = CP_W'(c);
        n_new     = 2'd3;
      end
    end else begin
      pend_we  = 1'b1;
      pcnt_nxt = pcnt_r + 2'd1;
    end
  end

  // Shift and size each code point
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cp_sh[i]   = raw_item ? cp_raw[i] : shift_cp(cp_raw[i], src_script, tgt_script);
      len_new[i] = raw_item ? 2'd0 : enc_len_m1(cp_sh[i]);
    end
  end

  // Gathering state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
      need_r <= 3'd0;
    end else if (cmd.load) begin
      pcnt_r <= pcnt_nxt;
      need_r <= need_nxt;
    end
  end

  // Pending byte store, written at the current fill level
  always_ff @(posedge clk) begin
    if (cmd.load && pend_we) begin
      pend_r[pcnt_r] <= c;
    end
  end

  // Capture the code points of an accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        cp_r[i]  <= cp_sh[i];
        len_r[i] <= len_new[i];
      end
      eot_r <= in_data.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncps_r <= 2'd0;
    end else if (cmd.load) begin
      ncps_r <= n_new;
    end
  end

  // Select the byte to emit
  assign cur_cp  = cp_r[cmd.cp_idx];
  assign cur_len = len_r[cmd.cp_idx];

  // Output register: fill on emit, drain on ready
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.out_byte  <= enc_byte(cur_cp, cur_len, cmd.byte_idx);
      out_data_r.run_last  <= cmd.run_last;
      out_data_r.text_done <= cmd.run_last && eot_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign sts.new_ncps   = n_new;
  assign sts.ncps       = ncps_r;
  assign sts.cur_len_m1 = cur_len;
  assign sts.slot_free  = !out_valid_r || out_ready;

  `include "utf8_indic_script_transliterator_core_macros.svh"

  `UIST_ASSERT_IMP(a_need_above_count, clk, rst_n, pcnt_r != 2'd0, need_r > 3'(pcnt_r), "pending count not below needed length")
  `UIST_ASSERT_IMP(a_idle_clear, clk, rst_n, pcnt_r == 2'd0, need_r == 3'd0, "needed length set with nothing pending")
  `UIST_ASSERT_NXT(a_emit_fills, clk, rst_n, cmd.emit, out_valid_r, "emitted byte missing from output register")

endmodule

FILE: hw/rtl/uist_ctrl.sv
// Controller: accepts transactions and steps through the bytes to emit.
module uist_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  uist_pkg::dp_sts_t sts,
  output uist_pkg::dp_cmd_t cmd
);
  import uist_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] cp_idx_r, cp_idx_nxt;
  logic [1:0] byte_idx_r, byte_idx_nxt;
  logic       last_byte;
  logic       last_cp;

  assign last_byte = (byte_idx_r == sts.cur_len_m1);
  assign last_cp   = ((3'(cp_idx_r) + 3'd1) == 3'(sts.ncps));

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cp_idx_r   <= 2'd0;
      byte_idx_r <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      cp_idx_r   <= cp_idx_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cp_idx_nxt   = cp_idx_r;
    byte_idx_nxt = byte_idx_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.cp_idx   = cp_idx_r;
    cmd.byte_idx = byte_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cp_idx_nxt   = 2'd0;
          byte_idx_nxt = 2'd0;
          if (sts.new_ncps != 2'd0) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.run_last = last_byte && last_cp;
          if (last_byte) begin
            byte_idx_nxt = 2'd0;
            cp_idx_nxt   = cp_idx_r + 2'd1;
          end else begin
            byte_idx_nxt = byte_idx_r + 2'd1;
          end
          // take the next transaction as the final byte leaves
          if (last_byte && last_cp) begin
            in_ready   = 1'b1;
            state_nxt  = ST_IDLE;
            cp_idx_nxt = 2'd0;
            if (in_valid) begin
              cmd.load = 1'b1;
              if (sts.new_ncps != 2'd0) begin
                state_nxt = ST_EMIT;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `include "utf8_indic_script_transliterator_core_macros.svh"

  `UIST_ASSERT_IMP(a_ready_on_last, clk, rst_n, state_r == ST_EMIT && in_ready, cmd.emit && cmd.run_last, "accepting before final byte")
  `UIST_ASSERT_IMP(a_cp_in_range, clk, rst_n, state_r == ST_EMIT, cp_idx_r < sts.ncps, "code point index beyond count")
  `UIST_ASSERT_IMP(a_byte_in_range, clk, rst_n, state_r == ST_EMIT, byte_idx_r <= sts.cur_len_m1, "byte index beyond length")

endmodule

FILE: hw/rtl/utf8_indic_script_transliterator_core.sv
// Top level of the streaming UTF-8 Indic script transliterator.
//
//   channel | ports                         | payload
//   --------+-------------------------------+-------------------------------
//   input   | in_valid / in_ready           | in_data  (in_byte, end_of_text)
//   result  | out_valid / out_ready         | out_data (out_byte, run_last,
//           |                               |           text_done)
//   config  | psel penable pwrite paddr ... | src_script @0x0, tgt_script @0x4
//
// A transaction releasing output bytes holds the controller as they go, one
// byte per cycle through the output register unless out_ready stalls; one that
// only gathers a byte does not hold it. The next transaction is taken in the
// cycle the final byte is loaded. A stalled out_ready holds the emit sequence;
// the output register lets one byte wait without blocking the next acceptance.
// Reset (synchronous, rst_n low) clears both scripts and the gathering state.
module utf8_indic_script_transliterator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uist_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output uist_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import uist_pkg::*;

  localparam logic REG_SRC = 1'b0;
  localparam logic REG_TGT = 1'b1;

  logic [1:0] src_script_r;
  logic [1:0] tgt_script_r;
  logic       cfg_wr;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_script_r <= SCRIPT_NONE;
      tgt_script_r <= SCRIPT_NONE;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SRC: src_script_r <= pwdata[1:0];
        REG_TGT: tgt_script_r <= pwdata[1:0];
        default: src_script_r <= src_script_r;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[2])
      REG_SRC: prdata = {30'd0, src_script_r};
      REG_TGT: prdata = {30'd0, tgt_script_r};
      default: prdata = 32'd0;
    endcase
  end

  uist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uist_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_script (src_script_r),
    .tgt_script (tgt_script_r),
    .in_data    (in_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
